FILE: hdl/port_scan_detector_macros.svh
// assertion macros used by the checker file
`ifndef PORT_SCAN_DETECTOR_MACROS_SVH
`define PORT_SCAN_DETECTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define PSD_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: label");

// next-cycle implication, disabled during reset
`define PSD_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: label");

`endif

FILE: hdl/psd_pkg.sv
package psd_pkg;

    // table geometry
    localparam int SOURCE_SLOTS     = 64;
    localparam int SLOT_W           = 6;
    localparam int SLOT_CNT_W       = 7;
    localparam int PORTS_PER_SOURCE = 16;
    localparam int PORT_IDX_W       = 4;
    localparam int MEM_PORTS        = SOURCE_SLOTS * PORTS_PER_SOURCE;
    localparam int PADDR_W          = SLOT_W + PORT_IDX_W;
    localparam int CNT_W            = 5;
    localparam int NOW_W            = 63;
    localparam int TNS_W            = 42;
    localparam logic [TNS_W-1:0] NS_PER_US = 42'd1000;

    // configuration register indexes
    localparam logic [7:0] REG_LAN_DEVICE = 8'd0;
    localparam logic [7:0] REG_WAN_DEVICE = 8'd1;
    localparam logic [7:0] REG_TIMEOUT_US = 8'd2;
    localparam logic [7:0] REG_PORT_LIMIT = 8'd3;

    // packet class decided at the front
    typedef enum logic [1:0] {
        CLS_NOL4,
        CLS_LAN,
        CLS_WAN,
        CLS_OTHER
    } psd_cls_t;

    // engine sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_LIM,
        ST_SWEEP,
        ST_PRD,
        ST_PEV,
        ST_UPD,
        ST_DONE
    } psd_state_t;

    // table update kinds
    typedef enum logic [1:0] {
        UPD_REFRESH,
        UPD_ADD,
        UPD_TAKE,
        UPD_SCAN
    } psd_upd_t;

    typedef struct packed {
        logic [3:0]  lan_device_id;
        logic [3:0]  wan_device_id;
        logic [31:0] timeout_us;
        logic [4:0]  port_limit;
    } psd_cfg_t;

    typedef struct packed {
        logic [3:0]       dev;
        logic [31:0]      src;
        logic [15:0]      port;
        logic [NOW_W-1:0] now;
        psd_cls_t         cls;
        logic [3:0]       odev;
        logic             verdict;
    } psd_item_t;

endpackage

FILE: hdl/port_scan_detector.sv
// Port scan filter. Packets enter through a two-entry request queue (push/full)
// and verdicts leave through a one-entry result register (empty/pop), in order,
// one result per packet. A packet without an L4 header goes straight to the
// result write. An L4 packet first forms the expiry limit (states MUL, LIM),
// then makes one pass over the 64 source slots (one slot read per cycle from the
// slot tables) that frees idle slots and, for a WAN packet, looks up the source,
// then for a known source reads and compares each stored port (at most 16) in
// the port table, then makes the table update where one is needed and the
// result write. There is no clearing pass after reset. Configuration writes are
// always taken (cfg_ready stays high) and are meant for an idle block.
module port_scan_detector
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  in_device,
    input  logic        has_l4,
    input  logic [31:0] source_ip,
    input  logic [15:0] dest_port,
    input  logic [62:0] now_ns,
    output logic        empty,
    input  logic        pop,
    output logic        verdict,
    output logic [3:0]  out_device,
    output logic        scan_detected,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    psd_pkg::psd_cfg_t  cfg;
    psd_pkg::psd_item_t item;
    logic               item_vld;
    logic               item_take;

    // request side: config, classify, queue
    psd_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_device (in_device),
        .has_l4    (has_l4),
        .source_ip (source_ip),
        .dest_port (dest_port),
        .now_ns    (now_ns),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .item_vld  (item_vld),
        .item      (item),
        .item_take (item_take)
    );

    // table engine and result register
    psd_engine u_engine
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .item_vld      (item_vld),
        .item          (item),
        .item_take     (item_take),
        .empty         (empty),
        .pop           (pop),
        .verdict       (verdict),
        .out_device    (out_device),
        .scan_detected (scan_detected)
    );

endmodule

FILE: hdl/psd_front.sv
module psd_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         in_device,
    input  logic               has_l4,
    input  logic [31:0]        source_ip,
    input  logic [15:0]        dest_port,
    input  logic [62:0]        now_ns,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output psd_pkg::psd_cfg_t  cfg,
    output logic               item_vld,
    output psd_pkg::psd_item_t item,
    input  logic               item_take
);

    psd_pkg::psd_cfg_t  cfg_reg;
    psd_pkg::psd_item_t q_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg;
    psd_pkg::psd_item_t cls_item;
    logic               do_push;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;
    assign full      = (cnt_reg == 2'd2);
    assign item_vld  = (cnt_reg != 2'd0);
    assign item      = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lan_device_id <= 4'd0;
            cfg_reg.wan_device_id <= 4'd1;
            cfg_reg.timeout_us    <= 32'd1000000;
            cfg_reg.port_limit    <= 5'd16;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                psd_pkg::REG_LAN_DEVICE: cfg_reg.lan_device_id <= cfg_data[3:0];
                psd_pkg::REG_WAN_DEVICE: cfg_reg.wan_device_id <= cfg_data[3:0];
                psd_pkg::REG_TIMEOUT_US: cfg_reg.timeout_us    <= cfg_data;
                psd_pkg::REG_PORT_LIMIT: cfg_reg.port_limit    <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // classify the request and precompute its scan-free verdict
    always_comb
    begin
        cls_item.dev  = in_device;
        cls_item.src  = source_ip;
        cls_item.port = dest_port;
        cls_item.now  = now_ns;
        if (!has_l4)
        begin
            cls_item.cls     = psd_pkg::CLS_NOL4;
            cls_item.odev    = in_device;
            cls_item.verdict = 1'b1;
        end
        else if (in_device == cfg_reg.lan_device_id)
        begin
            cls_item.cls     = psd_pkg::CLS_LAN;
            cls_item.odev    = cfg_reg.wan_device_id;
            cls_item.verdict = (cfg_reg.wan_device_id == in_device);
        end
        else if (in_device == cfg_reg.wan_device_id)
        begin
            cls_item.cls     = psd_pkg::CLS_WAN;
            cls_item.odev    = cfg_reg.lan_device_id;
            cls_item.verdict = (cfg_reg.lan_device_id == in_device);
        end
        else
        begin
            cls_item.cls     = psd_pkg::CLS_OTHER;
            cls_item.odev    = in_device;
            cls_item.verdict = 1'b1;
        end
    end

    // two-entry queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (item_take)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !item_take)
                cnt_reg <= cnt_reg + 2'd1;
            else if (!do_push && item_take)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= cls_item;
    end

endmodule

FILE: hdl/psd_engine.sv
module psd_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  psd_pkg::psd_cfg_t  cfg,
    input  logic               item_vld,
    input  psd_pkg::psd_item_t item,
    output logic               item_take,
    output logic               empty,
    input  logic               pop,
    output logic               verdict,
    output logic [3:0]         out_device,
    output logic               scan_detected
);

    psd_pkg::psd_state_t state_reg, state_next;
    psd_pkg::psd_item_t  cur_reg;
    psd_pkg::psd_upd_t   upd_reg, upd_next;

    logic [psd_pkg::TNS_W-1:0]      tns_reg;
    logic                           exp_en_reg;
    logic [psd_pkg::NOW_W-1:0]      limit_reg;
    logic [psd_pkg::SLOT_CNT_W-1:0] idx_reg, idx_next;
    logic                           ev_vld_reg, ev_vld_next;
    logic [psd_pkg::SLOT_W-1:0]     ev_idx_reg;
    logic [psd_pkg::SOURCE_SLOTS-1:0] valid_reg;
    logic                           match_fnd_reg;
    logic [psd_pkg::SLOT_W-1:0]     match_idx_reg;
    logic [psd_pkg::CNT_W-1:0]      match_cnt_reg;
    logic                           free_fnd_reg;
    logic [psd_pkg::SLOT_W-1:0]     free_idx_reg;
    logic [psd_pkg::CNT_W-1:0]      k_reg, k_next;

    logic                           res_vld_reg;
    logic                           res_verdict_reg;
    logic [3:0]                     res_dev_reg;
    logic                           res_scan_reg;

    // table memories
    logic [31:0]                    src_mem  [psd_pkg::SOURCE_SLOTS];
    logic [psd_pkg::NOW_W-1:0]      seen_mem [psd_pkg::SOURCE_SLOTS];
    logic [psd_pkg::CNT_W-1:0]      cnt_mem  [psd_pkg::SOURCE_SLOTS];
    logic [15:0]                    port_mem [psd_pkg::MEM_PORTS];
    logic [31:0]                    rd_src_reg;
    logic [psd_pkg::NOW_W-1:0]      rd_seen_reg;
    logic [psd_pkg::CNT_W-1:0]      rd_cnt_reg;
    logic [15:0]                    rd_port_reg;

    logic                           ev_live;
    logic                           ev_expire;
    logic [psd_pkg::CNT_W-1:0]      lim;
    logic [psd_pkg::SLOT_W-1:0]     wr_slot;
    logic [psd_pkg::PADDR_W-1:0]    prd_addr;
    logic                           upd_we;
    logic                           cnt_we;
    logic [psd_pkg::CNT_W-1:0]      cnt_wdata;
    logic                           port_we;
    logic [psd_pkg::PADDR_W-1:0]    port_waddr;
    logic                           res_load;

    assign empty         = !res_vld_reg;
    assign verdict       = res_verdict_reg;
    assign out_device    = res_dev_reg;
    assign scan_detected = res_scan_reg;

    // effective port limit
    assign lim = (cfg.port_limit > psd_pkg::CNT_W'(psd_pkg::PORTS_PER_SOURCE))
               ? psd_pkg::CNT_W'(psd_pkg::PORTS_PER_SOURCE) : cfg.port_limit;

    // sweep evaluation of the slot read last cycle
    assign ev_expire = exp_en_reg && (rd_seen_reg < limit_reg);
    assign ev_live   = valid_reg[ev_idx_reg] && !ev_expire;

    assign prd_addr  = {match_idx_reg, k_reg[psd_pkg::PORT_IDX_W-1:0]};
    assign wr_slot   = (upd_reg == psd_pkg::UPD_TAKE) ? free_idx_reg : match_idx_reg;
    assign upd_we    = (state_reg == psd_pkg::ST_UPD);
    assign res_load  = (state_reg == psd_pkg::ST_DONE) && (!res_vld_reg || pop);

    // write controls for count and port tables
    always_comb
    begin
        cnt_we     = 1'b0;
        cnt_wdata  = match_cnt_reg + psd_pkg::CNT_W'(1);
        port_we    = 1'b0;
        port_waddr = {match_idx_reg, match_cnt_reg[psd_pkg::PORT_IDX_W-1:0]};
        if (upd_we)
        begin
            case (upd_reg)
                psd_pkg::UPD_ADD:
                begin
                    cnt_we  = 1'b1;
                    port_we = 1'b1;
                end
                psd_pkg::UPD_TAKE:
                begin
                    cnt_we     = 1'b1;
                    cnt_wdata  = psd_pkg::CNT_W'(1);
                    port_we    = 1'b1;
                    port_waddr = {free_idx_reg, psd_pkg::PORT_IDX_W'(0)};
                end
                default: ;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        upd_next    = upd_reg;
        idx_next    = idx_reg;
        ev_vld_next = 1'b0;
        k_next      = k_reg;
        item_take   = 1'b0;
        case (state_reg)
            psd_pkg::ST_IDLE:
            begin
                if (item_vld)
                begin
                    item_take  = 1'b1;
                    state_next = (item.cls == psd_pkg::CLS_NOL4)
                               ? psd_pkg::ST_DONE : psd_pkg::ST_MUL;
                end
            end
            psd_pkg::ST_MUL:
                state_next = psd_pkg::ST_LIM;
            psd_pkg::ST_LIM:
            begin
                idx_next   = '0;
                state_next = psd_pkg::ST_SWEEP;
            end
            psd_pkg::ST_SWEEP:
            begin
                if (idx_reg < psd_pkg::SLOT_CNT_W'(psd_pkg::SOURCE_SLOTS))
                begin
                    ev_vld_next = 1'b1;
                    idx_next    = idx_reg + psd_pkg::SLOT_CNT_W'(1);
                end
                else if (!ev_vld_reg)
                begin
                    k_next = '0;
                    if (cur_reg.cls != psd_pkg::CLS_WAN)
                        state_next = psd_pkg::ST_DONE;
                    else if (match_fnd_reg)
                        state_next = psd_pkg::ST_PRD;
                    else if (free_fnd_reg)
                    begin
                        upd_next   = psd_pkg::UPD_TAKE;
                        state_next = psd_pkg::ST_UPD;
                    end
                    else
                        state_next = psd_pkg::ST_DONE;
                end
            end
            psd_pkg::ST_PRD:
            begin
                if (k_reg < match_cnt_reg)
                    state_next = psd_pkg::ST_PEV;
                else
                begin
                    upd_next   = (match_cnt_reg >= lim) ? psd_pkg::UPD_SCAN
                                                        : psd_pkg::UPD_ADD;
                    state_next = psd_pkg::ST_UPD;
                end
            end
            psd_pkg::ST_PEV:
            begin
                if (rd_port_reg == cur_reg.port)
                begin
                    upd_next   = psd_pkg::UPD_REFRESH;
                    state_next = psd_pkg::ST_UPD;
                end
                else
                begin
                    k_next     = k_reg + psd_pkg::CNT_W'(1);
                    state_next = psd_pkg::ST_PRD;
                end
            end
            psd_pkg::ST_UPD:
                state_next = psd_pkg::ST_DONE;
            psd_pkg::ST_DONE:
            begin
                if (res_load)
                    state_next = psd_pkg::ST_IDLE;
            end
            default:
                state_next = psd_pkg::ST_IDLE;
        endcase
    end

    // sequencer and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psd_pkg::ST_IDLE;
            upd_reg       <= psd_pkg::UPD_REFRESH;
            idx_reg       <= '0;
            ev_vld_reg    <= 1'b0;
            k_reg         <= '0;
            valid_reg     <= '0;
            match_fnd_reg <= 1'b0;
            free_fnd_reg  <= 1'b0;
            res_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            upd_reg    <= upd_next;
            idx_reg    <= idx_next;
            ev_vld_reg <= ev_vld_next;
            k_reg      <= k_next;
            if (item_take)
            begin
                match_fnd_reg <= 1'b0;
                free_fnd_reg  <= 1'b0;
            end
            // expiry and lookup on one pass over the slots
            if (ev_vld_reg)
            begin
                if (valid_reg[ev_idx_reg] && ev_expire)
                    valid_reg[ev_idx_reg] <= 1'b0;
                if (cur_reg.cls == psd_pkg::CLS_WAN)
                begin
                    if (ev_live && rd_src_reg == cur_reg.src && !match_fnd_reg)
                        match_fnd_reg <= 1'b1;
                    if (!ev_live && !free_fnd_reg)
                        free_fnd_reg <= 1'b1;
                end
            end
            if (upd_we && upd_reg == psd_pkg::UPD_TAKE)
                valid_reg[free_idx_reg] <= 1'b1;
            if (res_load)
                res_vld_reg <= 1'b1;
            else if (pop)
                res_vld_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (item_take)
            cur_reg <= item;
        tns_reg    <= {10'd0, cfg.timeout_us} * psd_pkg::NS_PER_US;
        exp_en_reg <= (cur_reg.now >= psd_pkg::NOW_W'(tns_reg));
        limit_reg  <= cur_reg.now - psd_pkg::NOW_W'(tns_reg);
        ev_idx_reg <= idx_reg[psd_pkg::SLOT_W-1:0];
        if (ev_vld_reg && cur_reg.cls == psd_pkg::CLS_WAN)
        begin
            if (ev_live && rd_src_reg == cur_reg.src && !match_fnd_reg)
            begin
                match_idx_reg <= ev_idx_reg;
                match_cnt_reg <= rd_cnt_reg;
            end
            if (!ev_live && !free_fnd_reg)
                free_idx_reg <= ev_idx_reg;
        end
        if (res_load)
        begin
            res_scan_reg    <= (upd_reg == psd_pkg::UPD_SCAN) && cur_reg.cls == psd_pkg::CLS_WAN
                               && match_fnd_reg;
            res_verdict_reg <= ((upd_reg == psd_pkg::UPD_SCAN) && cur_reg.cls == psd_pkg::CLS_WAN
                               && match_fnd_reg) ? 1'b1 : cur_reg.verdict;
            res_dev_reg     <= ((upd_reg == psd_pkg::UPD_SCAN) && cur_reg.cls == psd_pkg::CLS_WAN
                               && match_fnd_reg) ? cur_reg.dev : cur_reg.odev;
        end
    end

    // slot tables
    always_ff @(posedge clk)
    begin
        rd_src_reg  <= src_mem[idx_reg[psd_pkg::SLOT_W-1:0]];
        rd_seen_reg <= seen_mem[idx_reg[psd_pkg::SLOT_W-1:0]];
        rd_cnt_reg  <= cnt_mem[idx_reg[psd_pkg::SLOT_W-1:0]];
        if (upd_we)
            seen_mem[wr_slot] <= cur_reg.now;
        if (upd_we && upd_reg == psd_pkg::UPD_TAKE)
            src_mem[wr_slot] <= cur_reg.src;
        if (cnt_we)
            cnt_mem[wr_slot] <= cnt_wdata;
    end

    // port set table
    always_ff @(posedge clk)
    begin
        rd_port_reg <= port_mem[prd_addr];
        if (port_we)
            port_mem[port_waddr] <= cur_reg.port;
    end

endmodule

FILE: hdl/psd_checker.sv
`include "port_scan_detector_macros.svh"

module psd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       verdict,
    input logic [3:0] out_device,
    input logic       scan_detected,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // a detected scan is always a drop
    `PSD_ASSERT_IMPLY(a_scan_drops, clk, rst_n, !empty && scan_detected, verdict)
    // config writes never stall
    `PSD_ASSERT_IMPLY(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)
    // a waiting result holds until taken
    `PSD_ASSERT_NEXT(a_res_hold, clk, rst_n, !empty && !pop, !empty && $stable(verdict) && $stable(out_device) && $stable(scan_detected))

endmodule

bind port_scan_detector psd_checker u_psd_checker (.*);

FILE: bench/tb_port_scan_detector.sv
module tb_port_scan_detector;

    localparam int N_SLOTS  = 64;
    localparam int N_PORTS  = 16;
    localparam int WAN_SRCS = 24;

    typedef struct packed {
        logic       verdict;
        logic [3:0] out_device;
        logic       scan_detected;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [3:0]  in_device;
    logic        has_l4;
    logic [31:0] source_ip;
    logic [15:0] dest_port;
    logic [62:0] now_ns;
    logic        empty;
    logic        pop;
    logic        verdict;
    logic [3:0]  out_device;
    logic        scan_detected;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;

    // shadow of the filter registers and source table
    logic [3:0]  lan_dev;
    logic [3:0]  wan_dev;
    logic [31:0] idle_us;
    logic [4:0]  port_cap;
    logic        src_used [N_SLOTS];
    logic [31:0] src_ip [N_SLOTS];
    logic [63:0] src_seen [N_SLOTS];
    int          src_nports [N_SLOTS];
    logic [15:0] src_portset [N_SLOTS][N_PORTS];

    verdict_t    pending_verdicts[$];
    int          errors;
    int          n_sent;
    int          n_checked;
    int          n_scans;
    logic [62:0] clock_ns;
    logic [31:0] wan_pool [WAN_SRCS];

    port_scan_detector u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .in_device(in_device), .has_l4(has_l4), .source_ip(source_ip),
        .dest_port(dest_port), .now_ns(now_ns), .empty(empty), .pop(pop),
        .verdict(verdict), .out_device(out_device), .scan_detected(scan_detected),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("timeout at %0t", $time);
        $display("FAILED: results differ");
        $finish;
    end

    // shadow reset
    task automatic clear_table();
        for (int i = 0; i < N_SLOTS; i++)
        begin
            src_used[i] = 1'b0;
            src_nports[i] = 0;
        end
    endtask

    // expected verdict for one packet; updates the shadow table
    function automatic verdict_t filter_packet(logic [3:0] dev, logic l4,
                                               logic [31:0] src, logic [15:0] port,
                                               logic [62:0] now);
        verdict_t    v;
        logic [63:0] tns;
        logic [63:0] cutoff;
        logic [3:0]  odev;
        logic        scan;
        int          lim;
        int          hit;
        int          cnt;
        logic        seen;
        odev = dev;
        scan = 1'b0;
        if (l4)
        begin
            // free idle sources
            tns = 64'(idle_us) * 64'd1000;
            if (64'(now) >= tns)
            begin
                cutoff = 64'(now) - tns;
                for (int i = 0; i < N_SLOTS; i++)
                    if (src_used[i] && src_seen[i] < cutoff)
                    begin
                        src_used[i] = 1'b0;
                        src_nports[i] = 0;
                    end
            end
            if (dev == lan_dev)
                odev = wan_dev;
            else if (dev == wan_dev)
            begin
                lim = (port_cap > N_PORTS) ? N_PORTS : int'(port_cap);
                hit = -1;
                for (int i = 0; i < N_SLOTS; i++)
                    if (hit < 0 && src_used[i] && src_ip[i] == src)
                        hit = i;
                if (hit >= 0)
                begin
                    src_seen[hit] = 64'(now);
                    cnt = src_nports[hit];
                    seen = 1'b0;
                    for (int k = 0; k < cnt; k++)
                        if (src_portset[hit][k] == port)
                            seen = 1'b1;
                    if (!seen)
                    begin
                        if (cnt >= lim)
                            scan = 1'b1;
                        else
                        begin
                            src_portset[hit][cnt] = port;
                            src_nports[hit] = cnt + 1;
                        end
                    end
                end
                else
                begin
                    for (int i = 0; i < N_SLOTS; i++)
                        if (hit < 0 && !src_used[i])
                        begin
                            hit = i;
                            src_used[i] = 1'b1;
                            src_ip[i] = src;
                            src_seen[i] = 64'(now);
                            src_nports[i] = 1;
                            src_portset[i][0] = port;
                        end
                end
                if (!scan)
                    odev = lan_dev;
            end
        end
        v.verdict = (odev == dev);
        v.out_device = odev;
        v.scan_detected = scan;
        return v;
    endfunction

    // send one packet, with a random gap first at times
    task automatic send_packet(logic [3:0] dev, logic l4, logic [31:0] src,
                               logic [15:0] port, logic [62:0] now);
        if ($urandom_range(0, 3) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        push <= 1'b1;
        in_device <= dev;
        has_l4 <= l4;
        source_ip <= src;
        dest_port <= port;
        now_ns <= now;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_verdicts.push_back(filter_packet(dev, l4, src, port, now));
        n_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            psd_pkg::REG_LAN_DEVICE: lan_dev = val[3:0];
            psd_pkg::REG_WAN_DEVICE: wan_dev = val[3:0];
            psd_pkg::REG_TIMEOUT_US: idle_us = val;
            psd_pkg::REG_PORT_LIMIT: port_cap = val[4:0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(logic [3:0] lan, logic [3:0] wan, logic [31:0] tmo,
                              logic [4:0] lim);
        drain();
        write_reg(psd_pkg::REG_LAN_DEVICE, 32'(lan));
        write_reg(psd_pkg::REG_WAN_DEVICE, 32'(wan));
        write_reg(psd_pkg::REG_TIMEOUT_US, tmo);
        write_reg(psd_pkg::REG_PORT_LIMIT, 32'(lim));
        cfg_valid <= 1'b0;
    endtask

    // receiver: stalls in a pattern, checks each verdict
    initial
    begin
        verdict_t want;
        int       phase;
        phase = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            phase++;
            pop <= (phase % 37 < 25) ? 1'b1 : ($urandom_range(0, 2) == 0);
            @(posedge clk);
            if (pop && !empty && rst_n)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected verdict %b/%h/%b", $time, verdict,
                             out_device, scan_detected);
                    errors++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    n_checked++;
                    if (scan_detected)
                        n_scans++;
                    if (verdict !== want.verdict)
                    begin
                        $display("%0t: verdict exp %b got %b", $time, want.verdict,
                                 verdict);
                        errors++;
                    end
                    if (out_device !== want.out_device)
                    begin
                        $display("%0t: out_device exp %h got %h", $time,
                                 want.out_device, out_device);
                        errors++;
                    end
                    if (scan_detected !== want.scan_detected)
                    begin
                        $display("%0t: scan_detected exp %b got %b", $time,
                                 want.scan_detected, scan_detected);
                        errors++;
                    end
                end
            end
            // hold the pop decision through the edge before changing it
        end
    end

    // expire everything by a zero timeout at a later time
    task automatic clear_table_dut_timeout();
        set_config(4'd0, 4'd1, 32'd0, 5'd16);
        clock_ns = clock_ns + 63'd1000;
        send_packet(4'd2, 1'b1, 32'h0, 16'h0, clock_ns);
        clock_ns = clock_ns + 63'd1000;
        send_packet(4'd2, 1'b1, 32'h0, 16'h0, clock_ns);
    endtask

    // field extremes, devices, no-L4 drops and same-device handling
    task automatic test_devices();
        set_config(4'd0, 4'd1, 32'd1000000, 5'd16);
        send_packet(4'd0, 1'b0, 32'h0, 16'h0, 63'd0);
        send_packet(4'hf, 1'b1, 32'hffffffff, 16'hffff, 63'd10);
        send_packet(4'd0, 1'b1, 32'hffffffff, 16'hffff, 63'd20);
        send_packet(4'd1, 1'b1, 32'h0, 16'h0, 63'd30);
        send_packet(4'd1, 1'b1, 32'hffffffff, 16'hffff, 63'h7fffffffffffffff);
        set_config(4'hf, 4'hf, 32'hffffffff, 5'd16);
        send_packet(4'hf, 1'b1, 32'h12345678, 16'h8000, 63'h7fffffffffffffff);
        send_packet(4'd3, 1'b1, 32'h12345678, 16'h1, 63'h7fffffffffffffff);
        clear_table_dut_timeout();
    endtask

    // port limit, scan, refresh on drop and a limit of zero
    task automatic test_port_limit();
        set_config(4'd0, 4'd1, 32'd1000, 5'd2);
        clock_ns = 63'h0100_0000_0000;
        for (int p = 0; p < 4; p++)
            send_packet(4'd1, 1'b1, 32'hc0a80001, 16'(100 + p), clock_ns + 63'(p));
        send_packet(4'd1, 1'b1, 32'hc0a80001, 16'd100, clock_ns + 63'd10);
        set_config(4'd0, 4'd1, 32'd1000, 5'd0);
        send_packet(4'd1, 1'b1, 32'hc0a80001, 16'd999, clock_ns + 63'd20);
        send_packet(4'd1, 1'b1, 32'hc0a80001, 16'd101, clock_ns + 63'd30);
        // expiry: past timeout the slot is freed and its set cleared
        clock_ns = clock_ns + 63'd5_000_000;
        send_packet(4'd1, 1'b1, 32'hc0a80001, 16'd555, clock_ns);
        send_packet(4'd1, 1'b1, 32'hc0a80001, 16'd556, clock_ns);
    endtask

    // fill the whole table, then overflow
    task automatic test_table_full();
        set_config(4'd0, 4'd1, 32'hffffffff, 5'd16);
        for (int i = 0; i < N_SLOTS + 2; i++)
            send_packet(4'd1, 1'b1, 32'h0a000000 + 32'(i), 16'(i), clock_ns);
        clear_table_dut_timeout();
    endtask

    // random traffic over a few register settings
    task automatic test_random(int count, logic [3:0] lan, logic [3:0] wan,
                               logic [31:0] tmo, logic [4:0] lim);
        logic [3:0] dev;
        int         r;
        set_config(lan, wan, tmo, lim);
        for (int i = 0; i < WAN_SRCS; i++)
            wan_pool[i] = $urandom();
        for (int i = 0; i < count; i++)
        begin
            clock_ns = clock_ns + 63'($urandom_range(0, 3000));
            r = $urandom_range(0, 9);
            dev = (r < 6) ? wan : (r < 8) ? lan : 4'($urandom());
            send_packet(dev, ($urandom_range(0, 9) != 0),
                        (r < 9) ? wan_pool[$urandom_range(0, WAN_SRCS - 1)] : $urandom(),
                        16'($urandom_range(0, 19)) ^ (($urandom_range(0, 7) == 0) ?
                        16'($urandom()) : 16'h0),
                        clock_ns);
        end
    endtask

    initial
    begin
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_scans = 0;
        clock_ns = 63'd0;
        rst_n = 1'b0;
        push = 1'b0;
        in_device = 4'd0;
        has_l4 = 1'b0;
        source_ip = 32'd0;
        dest_port = 16'd0;
        now_ns = 63'd0;
        cfg_valid = 1'b0;
        cfg_index = psd_pkg::REG_LAN_DEVICE;
        cfg_data = 32'd0;
        lan_dev = 4'd0;
        wan_dev = 4'd1;
        idle_us = 32'd1000000;
        port_cap = 5'd16;
        clear_table();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_devices();
        test_port_limit();
        test_table_full();
        test_random(110, 4'd0, 4'd1, 32'd20, 5'd4);
        test_random(110, 4'd5, 4'hc, 32'd5, 5'd31);
        test_random(110, 4'd2, 4'd7, 32'd50, 5'd1);
        drain();
        $display("sent %0d packets, checked %0d verdicts, %0d scans flagged",
                 n_sent, n_checked, n_scans);
        if (errors == 0 && pending_verdicts.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/psd_pkg.sv
hdl/psd_front.sv
hdl/psd_engine.sv
hdl/port_scan_detector.sv
hdl/psd_checker.sv
bench/tb_port_scan_detector.sv
